@@ hdl/first_fit_block_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator_assert.svh
// Assertion macros shared by the allocator RTL. Each macro samples on clk and
// is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication: when cond holds, prop holds in that cycle.
`define FFBA_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication: when cond holds, prop holds in the next cycle.
`define FFBA_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ hdl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int OWNER_BITS_DEF = 8;

  localparam int OWNER_W = 8;
  localparam int COUNT_W = 11;
  localparam int START_W = 10;

  localparam logic [COUNT_W-1:0] POOL_RESET = COUNT_W'(1024);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [OWNER_W-1:0] owner_id;
    logic [COUNT_W-1:0] block_count;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [START_W-1:0] start_block;
    logic [COUNT_W-1:0] free_blocks;
  } out_item_t;

  // command from the front end to the table engine
  typedef struct packed {
    logic     go;
    in_item_t item;
  } eng_cmd_t;

  // completion status from the table engine
  typedef struct packed {
    logic      done;
    logic      busy;
    out_item_t res;
  } eng_status_t;

endpackage

@@ hdl/ffba_engine.sv @@
// ----------------------------------------------------------------------------
// ffba_engine
// Owner table and its scan sequencer. Clears the table after reset, then per
// item scans the pool once (read, test, write back) and, for a successful
// allocate, writes the claimed run in a second pass.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_assert.svh"

module ffba_engine #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int OWNER_BITS = ffba_pkg::OWNER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ffba_pkg::eng_cmd_t                  cmd,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]     pool_size,
  output ffba_pkg::eng_status_t               sts
);
  import ffba_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FILL  = 4'b1000
  } eng_state_t;

  logic [OWNER_BITS-1:0] mem [NUM_BLOCKS];
  logic [OWNER_BITS-1:0] mem_rd_r;

  eng_state_t            state_r, state_nxt;
  logic                  p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]      clr_idx_r, clr_idx_nxt;

  logic                  kind_r, kind_nxt;
  logic [OWNER_BITS-1:0] owner_r, owner_nxt;
  logic [COUNT_W-1:0]    want_r, want_nxt;
  logic [CNT_W-1:0]      pool_r, pool_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]      p_idx_r, p_idx_nxt;
  logic [CNT_W-1:0]      run_r, run_nxt;
  logic [CNT_W-1:0]      free_r, free_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      start_r, start_nxt;
  logic [IDX_W-1:0]      end_r, end_nxt;
  logic [IDX_W-1:0]      fill_idx_r, fill_idx_nxt;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [OWNER_BITS-1:0] wdata;
  logic                  rd_en;
  logic [IDX_W-1:0]      raddr;
  logic                  done;

  logic                  is_free;
  logic                  match;
  logic [CNT_W-1:0]      run_inc;
  logic                  want_hit;
  logic                  more_reads;

  // table storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      mem_rd_r <= mem[raddr];
    end
  end

  assign is_free    = (mem_rd_r == '0);
  assign match      = (owner_r != '0) && (mem_rd_r == owner_r);
  assign run_inc    = is_free ? (run_r + CNT_W'(1)) : '0;
  assign want_hit   = (kind_r == KIND_ALLOC) && !found_r && (want_r != '0) &&
                      (owner_r != '0) && (CW'(run_inc) == CW'(want_r));
  assign more_reads = (rd_idx_r < pool_r);

  always_comb begin
    state_nxt    = state_r;
    p_vld_nxt    = 1'b0;
    clr_idx_nxt  = clr_idx_r;
    kind_nxt     = kind_r;
    owner_nxt    = owner_r;
    want_nxt     = want_r;
    pool_nxt     = pool_r;
    rd_idx_nxt   = rd_idx_r;
    p_idx_nxt    = p_idx_r;
    run_nxt      = run_r;
    free_nxt     = free_r;
    found_nxt    = found_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    fill_idx_nxt = fill_idx_r;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    rd_en        = 1'b0;
    raddr        = '0;
    done         = 1'b0;

    case (state_r)
      S_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_idx_r;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(NUM_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.go) begin
          kind_nxt   = cmd.item.kind;
          owner_nxt  = OWNER_BITS'(cmd.item.owner_id);
          want_nxt   = cmd.item.block_count;
          pool_nxt   = pool_size;
          rd_idx_nxt = '0;
          run_nxt    = '0;
          free_nxt   = '0;
          found_nxt  = 1'b0;
          start_nxt  = '0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (more_reads) begin
          rd_en      = 1'b1;
          raddr      = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          p_vld_nxt  = 1'b1;
          p_idx_nxt  = rd_idx_r[IDX_W-1:0];
        end
        if (p_vld_r) begin
          if (kind_r == KIND_FREE) begin
            // release the entry read last cycle; it counts as free afterwards
            if (match) begin
              we    = 1'b1;
              waddr = p_idx_r;
            end
            free_nxt = free_r + CNT_W'(is_free || match);
          end else begin
            run_nxt  = run_inc;
            free_nxt = free_r + CNT_W'(is_free);
            if (want_hit) begin
              found_nxt = 1'b1;
              start_nxt = IDX_W'(CW'(p_idx_r) + CW'(1) - CW'(want_r));
              end_nxt   = p_idx_r;
            end
          end
        end else if (!more_reads) begin
          if (found_r) begin
            fill_idx_nxt = start_r;
            state_nxt    = S_FILL;
          end else begin
            done      = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_FILL: begin
        we           = 1'b1;
        waddr        = fill_idx_r;
        wdata        = owner_r;
        fill_idx_nxt = fill_idx_r + IDX_W'(1);
        if (fill_idx_r == end_r) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    sts.done            = done;
    sts.busy            = (state_r != S_IDLE);
    sts.res.ok          = (kind_r == KIND_FREE) || found_r;
    sts.res.start_block = found_r ? START_W'(start_r) : '0;
    sts.res.free_blocks = found_r ? COUNT_W'(CW'(free_r) - CW'(want_r))
                                  : COUNT_W'(free_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      p_vld_r   <= 1'b0;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      p_vld_r   <= p_vld_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    owner_r    <= owner_nxt;
    want_r     <= want_nxt;
    pool_r     <= pool_nxt;
    rd_idx_r   <= rd_idx_nxt;
    p_idx_r    <= p_idx_nxt;
    run_r      <= run_nxt;
    free_r     <= free_nxt;
    found_r    <= found_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    fill_idx_r <= fill_idx_nxt;
  end

  `FFBA_ASSERT_NEXT(a_done_single, sts.done, !sts.done, "done held for two cycles")
  `FFBA_ASSERT_IMPL(a_free_bound, sts.done, free_r <= pool_r, "free count above pool")
  `FFBA_ASSERT_IMPL(a_fill_range, state_r == S_FILL, found_r && (fill_idx_r <= end_r), "fill outside run")
  `FFBA_ASSERT_IMPL(a_read_in_pool, p_vld_r, CNT_W'(p_idx_r) < pool_r, "scan read outside pool")

endmodule

@@ hdl/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator of contiguous runs over a pool of owner-tagged blocks.
// ----------------------------------------------------------------------------
// After reset the owner table is cleared one block a cycle with busy high;
// configuration writes are taken during that pass. With P the managed pool
// size (blocks_in_use, capped at NUM_BLOCKS), a free item scans the P blocks
// of the pool, and an allocate item scans them and, when it succeeds, then
// writes each claimed block. The time is set by the scan of the owner
// table through its one read port, one block read per cycle, and by the
// write pass over the claimed run. busy drops in the cycle the result shows,
// so the next item may start then. Results appear for exactly one cycle on
// out_item with out_valid high and must be taken in that cycle; there is no
// way to hold them off.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int OWNER_BITS = ffba_pkg::OWNER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  ffba_pkg::in_item_t           in_item,
  output logic                         out_valid,
  output ffba_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ffba_pkg::COUNT_W-1:0] cfg_data
);
  import ffba_pkg::*;

  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [COUNT_W-1:0] blocks_in_use_r, blocks_in_use_nxt;
  logic [CNT_W-1:0]   pool_size;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r;
  eng_cmd_t           cmd;
  eng_status_t        sts;

  assign cfg_ready = 1'b1;

  always_comb begin
    blocks_in_use_nxt = blocks_in_use_r;
    if (cfg_valid && cfg_ready) begin
      blocks_in_use_nxt = cfg_data;
    end
  end

  // cap the pool at the table depth
  assign pool_size = (CW'(blocks_in_use_r) > CW'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                              : CNT_W'(blocks_in_use_r);

  assign busy = sts.busy;

  always_comb begin
    cmd.go   = start && !sts.busy;
    cmd.item = in_item;
  end

  ffba_engine #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .OWNER_BITS (OWNER_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .pool_size (pool_size),
    .sts       (sts)
  );

  assign out_valid_nxt = sts.done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_in_use_r <= POOL_RESET;
      out_valid_r     <= 1'b0;
    end else begin
      blocks_in_use_r <= blocks_in_use_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // hold the item for its strobe cycle
  always_ff @(posedge clk) begin
    if (sts.done) begin
      out_item_r <= sts.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ bench/first_fit_block_allocator_checker.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator_checker
// Watches the request, result and pool size channels of the allocator. Keeps
// its own owner table and pool size and computes the reply of every accepted
// request. Compares each reply, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_checker #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  ffba_pkg::in_item_t           in_item,
  input  logic                         out_valid,
  input  ffba_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [ffba_pkg::COUNT_W-1:0] cfg_data,
  output int                           outstanding,
  output int                           fail_count,
  output int                           granted,
  output int                           refused,
  output int                           released
);
  import ffba_pkg::*;

  logic [OWNER_W-1:0] owner_of [NUM_BLOCKS];
  logic [COUNT_W-1:0] pool_words;
  out_item_t          predicted_replies [$];
  int                 errs;
  int                 n_grant;
  int                 n_refuse;
  int                 n_release;

  // Claim the first free run or release an owner, then count the free blocks.
  function automatic out_item_t first_fit_apply(in_item_t req);
    int        span;
    int        run;
    int        idx;
    int        j;
    int        first;
    int        vacant;
    out_item_t rsp;
    span = (pool_words > NUM_BLOCKS) ? NUM_BLOCKS : int'(pool_words);
    rsp  = '0;
    if (req.kind == KIND_ALLOC) begin
      if (req.block_count != 0 && req.owner_id != 0) begin
        run = 0;
        for (idx = 0; idx < span && !rsp.ok; idx++) begin
          run = (owner_of[idx] == '0) ? run + 1 : 0;
          if (run == req.block_count) begin
            first = idx + 1 - run;
            for (j = first; j <= idx; j++)
              owner_of[j] = req.owner_id;
            rsp.ok          = 1'b1;
            rsp.start_block = START_W'(first);
          end
        end
      end
    end else begin
      // owner zero releases nothing but still reports success
      if (req.owner_id != 0) begin
        for (idx = 0; idx < span; idx++)
          if (owner_of[idx] == req.owner_id)
            owner_of[idx] = '0;
      end
      rsp.ok = 1'b1;
    end
    vacant = 0;
    for (idx = 0; idx < span; idx++)
      if (owner_of[idx] == '0)
        vacant++;
    rsp.free_blocks = COUNT_W'(vacant);
    return rsp;
  endfunction

  task automatic note_failure(string what, string expv, string actv);
    errs++;
    if (errs <= 10)
      $display("mismatch at %0t: %s expected %s got %s", $time, what, expv, actv);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      foreach (owner_of[b])
        owner_of[b] = '0;
      pool_words = POOL_RESET;
      predicted_replies.delete();
      errs      = 0;
      n_grant   = 0;
      n_refuse  = 0;
      n_release = 0;
    end else begin
      // retire first: a reply and the next request can share an edge
      if (out_valid) begin
        if (predicted_replies.size() == 0) begin
          note_failure("reply", "none", $sformatf("%h", out_item));
        end else begin
          want = predicted_replies.pop_front();
          if (out_item.ok !== want.ok)
            note_failure("ok", $sformatf("%0d", want.ok), $sformatf("%0d", out_item.ok));
          if (out_item.start_block !== want.start_block)
            note_failure("start_block", $sformatf("%0d", want.start_block),
                         $sformatf("%0d", out_item.start_block));
          if (out_item.free_blocks !== want.free_blocks)
            note_failure("free_blocks", $sformatf("%0d", want.free_blocks),
                         $sformatf("%0d", out_item.free_blocks));
        end
      end
      if (cfg_valid && cfg_ready)
        pool_words = cfg_data;
      if (start && !busy) begin
        want = first_fit_apply(in_item);
        predicted_replies.push_back(want);
        if (in_item.kind == KIND_FREE)
          n_release++;
        else if (want.ok)
          n_grant++;
        else
          n_refuse++;
      end
    end
    outstanding <= predicted_replies.size();
    fail_count  <= errs;
    granted     <= n_grant;
    refused     <= n_refuse;
    released    <= n_release;
  end

endmodule

@@ bench/first_fit_block_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Drives allocate and release requests into the allocator across a range of
// pool sizes, from a short directed list into random traffic with shifting
// issue gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int NUM_BLOCKS   = NUM_BLOCKS_DEF;
  localparam int IDLE_LIMIT   = 16000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 24;
  localparam int WIDE_ITEMS   = 6;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [COUNT_W-1:0] cfg_data  = '0;
  in_item_t           in_item   = '0;
  logic               busy;
  logic               out_valid;
  out_item_t          out_item;
  logic               cfg_ready;

  int outstanding;
  int fail_count;
  int granted;
  int refused;
  int released;
  int sender_idle_pct = 0;
  int pool_span       = NUM_BLOCKS;
  int sent            = 0;
  int settings        = 0;
  int quiet_cycles    = 0;

  first_fit_block_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  first_fit_block_allocator_checker #(.NUM_BLOCKS(NUM_BLOCKS)) alloc_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count),
    .granted     (granted),
    .refused     (refused),
    .released    (released)
  );

  always #1 clk = ~clk;

  // end the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("no progress for %0d cycles", IDLE_LIMIT);
      $display("first_fit_block_allocator_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drop start and hold until every reply is back
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_pool(input logic [COUNT_W-1:0] words);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= words;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_span = (words > NUM_BLOCKS) ? NUM_BLOCKS : int'(words);
    settings++;
  endtask

  task automatic issue(input logic kind, input int owner, input int count);
    in_item_t req;
    req.kind        = kind;
    req.owner_id    = OWNER_W'(owner);
    req.block_count = COUNT_W'(count);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, pool_span + 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // mostly live owners claiming modest runs and releasing them, plus misuse
  task automatic random_request();
    int pick;
    int who;
    int modest;
    who    = ($urandom_range(99) < 15) ? $urandom_range(1, 255) : $urandom_range(1, 6);
    modest = pool_span / 3 + 1;
    if ($urandom_range(99) < 4)
      settle();
    pick = $urandom_range(99);
    if (pick < 52)
      issue(KIND_ALLOC, who, $urandom_range(1, modest));
    else if (pick < 78)
      issue(KIND_FREE, who, $urandom_range(0, 2047));
    else if (pick < 87)
      issue(KIND_ALLOC, who, $urandom_range(1, pool_span + 2));
    else if (pick < 91)
      issue(KIND_ALLOC, who, 0);
    else if (pick < 95)
      issue(($urandom_range(1) == 1) ? KIND_FREE : KIND_ALLOC, 0,
            $urandom_range(0, pool_span + 2));
    else
      issue(KIND_ALLOC, $urandom_range(1, 255), $urandom_range(0, 2047));
  endtask

  initial begin
    int                 ph;
    logic [COUNT_W-1:0] words;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // oversized setting caps at the full table
    set_pool(COUNT_W'(2047));
    issue(KIND_ALLOC, 255, 1024);
    issue(KIND_ALLOC, 1, 1);
    issue(KIND_FREE, 255, 2047);
    issue(KIND_ALLOC, 0, 5);
    issue(KIND_ALLOC, 3, 0);
    issue(KIND_ALLOC, 3, 2047);
    issue(KIND_ALLOC, 7, 10);
    issue(KIND_ALLOC, 8, 3);
    issue(KIND_FREE, 7, 0);
    issue(KIND_ALLOC, 9, 12);
    issue(KIND_ALLOC, 10, 10);
    issue(KIND_FREE, 0, 0);
    issue(KIND_FREE, 200, 0);
    issue(KIND_ALLOC, 128, 1000);
    // empty pool
    set_pool('0);
    issue(KIND_ALLOC, 5, 1);
    issue(KIND_FREE, 8, 0);
    // shrink: owners past the pool edge must stay put
    set_pool(COUNT_W'(16));
    issue(KIND_ALLOC, 4, 1);
    issue(KIND_FREE, 9, 0);
    issue(KIND_ALLOC, 4, 3);
    set_pool(COUNT_W'(1024));
    issue(KIND_FREE, 9, 0);
    issue(KIND_FREE, 10, 0);

    for (ph = 0; ph < PHASES; ph++) begin
      sender_idle_pct = (ph < 4) ? 24 : (ph < 8) ? 69 : 0;
      case (ph)
        0:       words = COUNT_W'(1);
        5:       words = COUNT_W'(1024);
        9:       words = COUNT_W'($urandom_range(65, 200));
        default: words = COUNT_W'($urandom_range(2, 64));
      endcase
      set_pool(words);
      repeat ((ph == 5) ? WIDE_ITEMS : PHASE_ITEMS)
        random_request();
    end

    settle();
    repeat (2 * pool_span + 16) @(posedge clk);
    $display("covered %0d requests over %0d pool sizes, with gapped and back-to-back issue",
             sent, settings);
    $display("%0d runs granted, %0d refused, %0d releases, %0d failures",
             granted, refused, released, fail_count);
    if (fail_count == 0 && outstanding == 0)
      $display("first_fit_block_allocator_tb: clean");
    else
      $display("first_fit_block_allocator_tb: errors");
    $finish;
  end

endmodule

@@ first_fit_block_allocator.f @@
+incdir+hdl
hdl/ffba_pkg.sv
hdl/ffba_engine.sv
hdl/first_fit_block_allocator.sv
bench/first_fit_block_allocator_checker.sv
bench/first_fit_block_allocator_tb.sv
